/* hdl/wse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wse_pkg;

  localparam int DATA_W = 64;
  localparam int MODE_W = 4;
  localparam int OFF_W = 10;
  localparam int CNT_W = 9;
  localparam int DEPTH_W = 9;
  localparam int ERR_W = 2;
  localparam int STACK_DEPTH_DEF = 256;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH      = 4'd0,
    MODE_POP       = 4'd1,
    MODE_DROP      = 4'd2,
    MODE_DUP       = 4'd3,
    MODE_OVER      = 4'd4,
    MODE_SWAP      = 4'd5,
    MODE_NIP       = 4'd6,
    MODE_TUCK      = 4'd7,
    MODE_PICK      = 4'd8,
    MODE_ROLL_UP   = 4'd9,
    MODE_ROLL_DOWN = 4'd10,
    MODE_READ      = 4'd11,
    MODE_WRITE     = 4'd12,
    MODE_INSERT    = 4'd13,
    MODE_DELETE    = 4'd14,
    MODE_CLEAR     = 4'd15
  } mode_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_RANGE = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CATCH,
    S_SWAP,
    S_MOVE,
    S_TAIL,
    S_TAIL2,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

/* hdl/word_stack_engine.sv */
// Word stack with Forth-style operations over a single memory.
// Input channel: in_valid_i / in_stall_o carry one request (mode, value,
// offset, count). Output channel: out_valid_o / out_stall_i carry one result
// (result_word, depth, error) per request, from an output register.
// A request is taken only in the idle state, while the output register is
// empty or being drained in that cycle; one request is worked on at a time.
// Each request passes, in order, through the steps that it needs: fetch a
// word, catch it, swap it with the word below, move a block, write the tail
// word (and for tuck a second tail word), then post the result in S_DONE.
// Drop, clear, a roll with count below 2 and any error go straight to S_DONE.
// Block moves cover count - 1 words for a roll, depth - p words for insert at
// position p and depth - q words for delete at q.
// The store has one registered read port and one write port; block moves
// stream one word per cycle through them.
// Reset clears the depth and the output register; the store itself is not
// cleared, and no entry at or above the depth is ever read.
// A stalled result holds in the output register, and no new request is taken
// until it leaves.
`timescale 1ns / 1ps
`default_nettype none

module word_stack_engine #(
  parameter int STACK_DEPTH = wse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [wse_pkg::MODE_W-1:0]  mode_i,
  input  wire logic signed [wse_pkg::DATA_W-1:0] value_i,
  input  wire logic signed [wse_pkg::OFF_W-1:0]  offset_i,
  input  wire logic [wse_pkg::CNT_W-1:0]   count_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [wse_pkg::DATA_W-1:0] result_word_o,
  output logic [wse_pkg::DEPTH_W-1:0]      depth_o,
  output logic [wse_pkg::ERR_W-1:0]        error_o
);

  localparam int DW = wse_pkg::DATA_W;
  localparam int OW = wse_pkg::OFF_W;
  localparam int KW = wse_pkg::CNT_W;
  localparam int TW = wse_pkg::DEPTH_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = ((CW > OW) ? CW : OW) + 2;

  wse_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            pw_valid_q, pw_valid_d;

  logic            swap_q, move_q, tail_q, tail2_q, tailv_q, res_q;
  wse_pkg::err_e   err_q;
  logic [CW-1:0]   nn_q;
  logic [AW-1:0]   fa_q, ta_q, t2_q, ms_q, md_q, pw_addr_q;
  logic            mdn_q;
  logic [CW-1:0]   mc_q;
  logic [DW-1:0]   value_q, w_q;
  logic [DW-1:0]   result_q;
  logic [TW-1:0]   depth_q;
  wse_pkg::err_e   error_q;

  logic [AW-1:0]   ms_d, md_d, pw_addr_d;
  logic [CW-1:0]   mc_d;
  logic [DW-1:0]   w_d;

  logic            dc_fetch, dc_swap, dc_move, dc_tail, dc_tail2, dc_tailv, dc_res, dc_mdn;
  wse_pkg::err_e   dc_err;
  logic [CW-1:0]   dc_nn, dc_mc;
  logic [AW-1:0]   dc_fa, dc_ta, dc_t2, dc_ms, dc_md;

  logic            accept;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [DW-1:0]   mem_wdata, mem_rdata;

  logic [OW-1:0]          sel_off;
  logic signed [PW-1:0]   n_w, k_w, off_w, pos_w;
  logic signed [PW-1:0]   nm1_w, nm2_w, np1_w, nmk_w, nmk1_w, km1_w, pmk_w, nmp_w;
  logic                   in_rng, pos_lt, full;
  logic [TW+CW-1:0]       depth_ext;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = !((state_q == wse_pkg::S_IDLE) && (!out_valid_q || !out_stall_i));

  assign sel_off = (wse_pkg::mode_e'(mode_i) == wse_pkg::MODE_DELETE) ? ~offset_i : offset_i;
  assign n_w    = {{(PW-CW){1'b0}}, cnt_q};
  assign k_w    = {{(PW-KW){1'b0}}, count_i};
  assign off_w  = {{(PW-OW){sel_off[OW-1]}}, sel_off};
  assign pos_w  = off_w[PW-1] ? (off_w + n_w + PW'(1)) : off_w;
  assign in_rng = !pos_w[PW-1] && (pos_w <= n_w);
  assign pos_lt = pos_w < n_w;
  assign full   = n_w == PW'(STACK_DEPTH);
  assign nm1_w  = n_w - PW'(1);
  assign nm2_w  = n_w - PW'(2);
  assign np1_w  = n_w + PW'(1);
  assign nmk_w  = n_w - k_w;
  assign nmk1_w = n_w - k_w + PW'(1);
  assign km1_w  = k_w - PW'(1);
  assign pmk_w  = pos_w - k_w;
  assign nmp_w  = n_w - pos_w;

  always_comb begin
    dc_fetch = 1'b0;
    dc_swap  = 1'b0;
    dc_move  = 1'b0;
    dc_tail  = 1'b0;
    dc_tail2 = 1'b0;
    dc_tailv = 1'b0;
    dc_res   = 1'b0;
    dc_mdn   = 1'b0;
    dc_err   = wse_pkg::ERR_OK;
    dc_nn    = cnt_q;
    dc_mc    = '0;
    dc_fa    = nm1_w[AW-1:0];
    dc_ta    = cnt_q[AW-1:0];
    dc_t2    = cnt_q[AW-1:0];
    dc_ms    = nm1_w[AW-1:0];
    dc_md    = cnt_q[AW-1:0];
    case (wse_pkg::mode_e'(mode_i))
      wse_pkg::MODE_PUSH: begin
        if (full) begin
          dc_err = wse_pkg::ERR_OVER;
        end else begin
          dc_tail  = 1'b1;
          dc_tailv = 1'b1;
          dc_nn    = np1_w[CW-1:0];
        end
      end
      wse_pkg::MODE_POP: begin
        if (cnt_q == '0) begin
          dc_err = wse_pkg::ERR_UNDER;
        end else begin
          dc_fetch = 1'b1;
          dc_res   = 1'b1;
          dc_nn    = nm1_w[CW-1:0];
        end
      end
      wse_pkg::MODE_DROP: begin
        if (k_w > n_w) begin
          dc_err = wse_pkg::ERR_UNDER;
        end else begin
          dc_nn = nmk_w[CW-1:0];
        end
      end
      wse_pkg::MODE_DUP, wse_pkg::MODE_OVER: begin
        if ((wse_pkg::mode_e'(mode_i) == wse_pkg::MODE_DUP) ? (n_w < PW'(1))
                                                           : (n_w < PW'(2))) begin
          dc_err = wse_pkg::ERR_UNDER;
        end else if (full) begin
          dc_err = wse_pkg::ERR_OVER;
        end else begin
          dc_fetch = 1'b1;
          dc_tail  = 1'b1;
          dc_fa    = (wse_pkg::mode_e'(mode_i) == wse_pkg::MODE_DUP) ? nm1_w[AW-1:0]
                                                                     : nm2_w[AW-1:0];
          dc_nn    = np1_w[CW-1:0];
        end
      end
      wse_pkg::MODE_SWAP: begin
        if (n_w < PW'(2)) begin
          dc_err = wse_pkg::ERR_UNDER;
        end else begin
          dc_fetch = 1'b1;
          dc_swap  = 1'b1;
          dc_tail  = 1'b1;
          dc_ta    = nm2_w[AW-1:0];
        end
      end
      wse_pkg::MODE_NIP: begin
        if (n_w < PW'(2)) begin
          dc_err = wse_pkg::ERR_UNDER;
        end else begin
          dc_fetch = 1'b1;
          dc_tail  = 1'b1;
          dc_ta    = nm2_w[AW-1:0];
          dc_nn    = nm1_w[CW-1:0];
        end
      end
      wse_pkg::MODE_TUCK: begin
        if (n_w < PW'(2)) begin
          dc_err = wse_pkg::ERR_UNDER;
        end else if (full) begin
          dc_err = wse_pkg::ERR_OVER;
        end else begin
          dc_fetch = 1'b1;
          dc_swap  = 1'b1;
          dc_tail  = 1'b1;
          dc_tail2 = 1'b1;
          dc_ta    = nm2_w[AW-1:0];
          dc_nn    = np1_w[CW-1:0];
        end
      end
      wse_pkg::MODE_PICK: begin
        if (!(in_rng && pos_lt)) begin
          dc_err = wse_pkg::ERR_RANGE;
        end else if (full) begin
          dc_err = wse_pkg::ERR_OVER;
        end else begin
          dc_fetch = 1'b1;
          dc_tail  = 1'b1;
          dc_fa    = pos_w[AW-1:0];
          dc_nn    = np1_w[CW-1:0];
        end
      end
      wse_pkg::MODE_ROLL_UP: begin
        if (k_w > n_w) begin
          dc_err = wse_pkg::ERR_UNDER;
        end else if (k_w >= PW'(2)) begin
          dc_fetch = 1'b1;
          dc_move  = 1'b1;
          dc_tail  = 1'b1;
          dc_mdn   = 1'b1;
          dc_ms    = nm2_w[AW-1:0];
          dc_md    = nm1_w[AW-1:0];
          dc_mc    = km1_w[CW-1:0];
          dc_ta    = nmk_w[AW-1:0];
        end
      end
      wse_pkg::MODE_ROLL_DOWN: begin
        if (k_w > n_w) begin
          dc_err = wse_pkg::ERR_UNDER;
        end else if (k_w >= PW'(2)) begin
          dc_fetch = 1'b1;
          dc_move  = 1'b1;
          dc_tail  = 1'b1;
          dc_fa    = nmk_w[AW-1:0];
          dc_ms    = nmk1_w[AW-1:0];
          dc_md    = nmk_w[AW-1:0];
          dc_mc    = km1_w[CW-1:0];
          dc_ta    = nm1_w[AW-1:0];
        end
      end
      wse_pkg::MODE_READ: begin
        if (!(in_rng && pos_lt)) begin
          dc_err = wse_pkg::ERR_RANGE;
        end else begin
          dc_fetch = 1'b1;
          dc_res   = 1'b1;
          dc_fa    = pos_w[AW-1:0];
        end
      end
      wse_pkg::MODE_WRITE: begin
        if (!(in_rng && pos_lt)) begin
          dc_err = wse_pkg::ERR_RANGE;
        end else begin
          dc_tail  = 1'b1;
          dc_tailv = 1'b1;
          dc_ta    = pos_w[AW-1:0];
        end
      end
      wse_pkg::MODE_INSERT: begin
        if (!in_rng) begin
          dc_err = wse_pkg::ERR_RANGE;
        end else if (full) begin
          dc_err = wse_pkg::ERR_OVER;
        end else begin
          dc_move  = 1'b1;
          dc_tail  = 1'b1;
          dc_tailv = 1'b1;
          dc_mdn   = 1'b1;
          dc_ms    = nm1_w[AW-1:0];
          dc_md    = cnt_q[AW-1:0];
          dc_mc    = nmp_w[CW-1:0];
          dc_ta    = pos_w[AW-1:0];
          dc_nn    = np1_w[CW-1:0];
        end
      end
      wse_pkg::MODE_DELETE: begin
        if (!in_rng) begin
          dc_err = wse_pkg::ERR_RANGE;
        end else if (k_w > pos_w) begin
          dc_err = wse_pkg::ERR_UNDER;
        end else begin
          dc_move = 1'b1;
          dc_ms   = pos_w[AW-1:0];
          dc_md   = pmk_w[AW-1:0];
          dc_mc   = nmp_w[CW-1:0];
          dc_nn   = nmk_w[CW-1:0];
        end
      end
      wse_pkg::MODE_CLEAR: begin
        dc_nn = '0;
      end
      default: begin
        dc_nn = cnt_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      wse_pkg::S_IDLE: begin
        if (accept) begin
          if (dc_fetch) begin
            state_d = wse_pkg::S_FETCH;
          end else if (dc_move) begin
            state_d = wse_pkg::S_MOVE;
          end else if (dc_tail) begin
            state_d = wse_pkg::S_TAIL;
          end else begin
            state_d = wse_pkg::S_DONE;
          end
        end
      end
      wse_pkg::S_FETCH: begin
        state_d = wse_pkg::S_CATCH;
      end
      wse_pkg::S_CATCH: begin
        if (swap_q) begin
          state_d = wse_pkg::S_SWAP;
        end else if (move_q) begin
          state_d = wse_pkg::S_MOVE;
        end else if (tail_q) begin
          state_d = wse_pkg::S_TAIL;
        end else begin
          state_d = wse_pkg::S_DONE;
        end
      end
      wse_pkg::S_SWAP: begin
        state_d = wse_pkg::S_TAIL;
      end
      wse_pkg::S_MOVE: begin
        if (mc_q == '0) begin
          state_d = tail_q ? wse_pkg::S_TAIL : wse_pkg::S_DONE;
        end
      end
      wse_pkg::S_TAIL: begin
        state_d = tail2_q ? wse_pkg::S_TAIL2 : wse_pkg::S_DONE;
      end
      wse_pkg::S_TAIL2: begin
        state_d = wse_pkg::S_DONE;
      end
      wse_pkg::S_DONE: begin
        state_d = wse_pkg::S_IDLE;
      end
      default: begin
        state_d = wse_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = ta_q;
    mem_raddr   = fa_q;
    mem_wdata   = w_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    pw_valid_d  = 1'b0;
    pw_addr_d   = pw_addr_q;
    ms_d        = ms_q;
    md_d        = md_q;
    mc_d        = mc_q;
    w_d         = w_q;
    case (state_q)
      wse_pkg::S_IDLE: begin
        ms_d = dc_ms;
        md_d = dc_md;
        mc_d = dc_mc;
      end
      wse_pkg::S_FETCH: begin
        mem_re = 1'b1;
      end
      wse_pkg::S_CATCH: begin
        w_d       = mem_rdata;
        mem_re    = swap_q;
        mem_raddr = ta_q;
      end
      wse_pkg::S_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = fa_q;
        mem_wdata = mem_rdata;
      end
      wse_pkg::S_MOVE: begin
        if (mc_q != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = ms_q;
          pw_valid_d = 1'b1;
          pw_addr_d  = md_q;
          ms_d       = mdn_q ? (ms_q - AW'(1)) : (ms_q + AW'(1));
          md_d       = mdn_q ? (md_q - AW'(1)) : (md_q + AW'(1));
          mc_d       = mc_q - CW'(1);
        end
        if (pw_valid_q) begin
          mem_we    = 1'b1;
          mem_waddr = pw_addr_q;
          mem_wdata = mem_rdata;
        end
      end
      wse_pkg::S_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = ta_q;
        mem_wdata = tailv_q ? value_q : w_q;
      end
      wse_pkg::S_TAIL2: begin
        mem_we    = 1'b1;
        mem_waddr = t2_q;
        mem_wdata = w_q;
      end
      wse_pkg::S_DONE: begin
        cnt_d       = nn_q;
        out_valid_d = 1'b1;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wse_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pw_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      pw_valid_q  <= pw_valid_d;
    end
  end

  assign depth_ext = {{TW{1'b0}}, nn_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      swap_q  <= dc_swap;
      move_q  <= dc_move;
      tail_q  <= dc_tail;
      tail2_q <= dc_tail2;
      tailv_q <= dc_tailv;
      res_q   <= dc_res;
      mdn_q   <= dc_mdn;
      err_q   <= dc_err;
      nn_q    <= dc_nn;
      fa_q    <= dc_fa;
      ta_q    <= dc_ta;
      t2_q    <= dc_t2;
      value_q <= value_i;
    end
    ms_q      <= ms_d;
    md_q      <= md_d;
    mc_q      <= mc_d;
    pw_addr_q <= pw_addr_d;
    w_q       <= w_d;
    if (state_q == wse_pkg::S_DONE) begin
      result_q <= res_q ? w_q : '0;
      depth_q  <= depth_ext[TW-1:0];
      error_q  <= err_q;
    end
  end

  wse_ram #(
    .WIDTH(DW),
    .DEPTH(STACK_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign result_word_o = result_q;
  assign depth_o       = depth_q;
  assign error_o       = error_q;

endmodule

`default_nettype wire

/* hdl/wse_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module wse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* dv/word_stack_engine_test.sv */
`timescale 1ns / 1ps

module word_stack_engine_test;
  import wse_pkg::*;

  localparam int STACK_WORDS = STACK_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [DATA_W-1:0]  word;
    logic [DEPTH_W-1:0] depth;
    logic [ERR_W-1:0]   error;
  } stack_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  mode_e mode_i = MODE_PUSH;
  logic signed [DATA_W-1:0] value_i = '0;
  logic signed [OFF_W-1:0] offset_i = '0;
  logic [CNT_W-1:0] count_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] result_word_o;
  logic [DEPTH_W-1:0] depth_o;
  logic [ERR_W-1:0] error_o;

  logic [DATA_W-1:0] stack_words [STACK_WORDS];
  int stack_level = 0;
  stack_result_t results_due [$];
  int failures = 0;
  int quiet_cycles = 0;
  int hold_cycles = 0;
  bit src_idling = 1'b1;
  bit sink_idling = 1'b1;

  word_stack_engine uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .offset_i     (offset_i),
    .count_i      (count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_word_o(result_word_o),
    .depth_o      (depth_o),
    .error_o      (error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic stack_result_t apply_request(input mode_e op,
                                                  input logic [DATA_W-1:0] word,
                                                  input logic signed [OFF_W-1:0] off,
                                                  input logic [CNT_W-1:0] cnt);
    stack_result_t r;
    int n, c, p, j;
    logic [DATA_W-1:0] w;
    n = stack_level;
    c = cnt;
    p = off;
    if (p < 0) p += n + 1;
    r.word = '0;
    r.error = ERR_OK;
    case (op)
      MODE_PUSH: begin
        if (n >= STACK_WORDS) r.error = ERR_OVER;
        else begin
          stack_words[n] = word;
          n++;
        end
      end
      MODE_POP: begin
        if (n < 1) r.error = ERR_UNDER;
        else begin
          n--;
          r.word = stack_words[n];
        end
      end
      MODE_DROP: begin
        if (c > n) r.error = ERR_UNDER;
        else n -= c;
      end
      MODE_DUP, MODE_OVER: begin
        j = (op == MODE_DUP) ? 1 : 2;
        if (n < j) r.error = ERR_UNDER;
        else if (n >= STACK_WORDS) r.error = ERR_OVER;
        else begin
          stack_words[n] = stack_words[n-j];
          n++;
        end
      end
      MODE_SWAP: begin
        if (n < 2) r.error = ERR_UNDER;
        else begin
          w = stack_words[n-1];
          stack_words[n-1] = stack_words[n-2];
          stack_words[n-2] = w;
        end
      end
      MODE_NIP: begin
        if (n < 2) r.error = ERR_UNDER;
        else begin
          stack_words[n-2] = stack_words[n-1];
          n--;
        end
      end
      MODE_TUCK: begin
        if (n < 2) r.error = ERR_UNDER;
        else if (n >= STACK_WORDS) r.error = ERR_OVER;
        else begin
          w = stack_words[n-1];
          stack_words[n-1] = stack_words[n-2];
          stack_words[n-2] = w;
          stack_words[n] = w;
          n++;
        end
      end
      MODE_PICK: begin
        if (p < 0 || p >= n) r.error = ERR_RANGE;
        else if (n >= STACK_WORDS) r.error = ERR_OVER;
        else begin
          stack_words[n] = stack_words[p];
          n++;
        end
      end
      MODE_ROLL_UP: begin
        if (c > n) r.error = ERR_UNDER;
        else if (c >= 2) begin
          w = stack_words[n-1];
          for (j = n - 1; j > n - c; j--) stack_words[j] = stack_words[j-1];
          stack_words[n-c] = w;
        end
      end
      MODE_ROLL_DOWN: begin
        if (c > n) r.error = ERR_UNDER;
        else if (c >= 2) begin
          w = stack_words[n-c];
          for (j = n - c; j < n - 1; j++) stack_words[j] = stack_words[j+1];
          stack_words[n-1] = w;
        end
      end
      MODE_READ: begin
        if (p < 0 || p >= n) r.error = ERR_RANGE;
        else r.word = stack_words[p];
      end
      MODE_WRITE: begin
        if (p < 0 || p >= n) r.error = ERR_RANGE;
        else stack_words[p] = word;
      end
      MODE_INSERT: begin
        if (p < 0 || p > n) r.error = ERR_RANGE;
        else if (n >= STACK_WORDS) r.error = ERR_OVER;
        else begin
          for (j = n; j > p; j--) stack_words[j] = stack_words[j-1];
          stack_words[p] = word;
          n++;
        end
      end
      MODE_DELETE: begin
        // position is mirrored: offset 0 is past the top, -1 the bottom
        p = -int'(off) - 1;
        if (p < 0) p += n + 1;
        if (p < 0 || p > n) r.error = ERR_RANGE;
        else if (c > p) r.error = ERR_UNDER;
        else begin
          for (j = p; j < n; j++) stack_words[j-c] = stack_words[j];
          n -= c;
        end
      end
      default: n = 0;
    endcase
    if (r.error == ERR_OK) stack_level = n;
    else r.word = '0;
    r.depth = stack_level[DEPTH_W-1:0];
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 15))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return '0;
      3: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_request(input mode_e op, input logic [DATA_W-1:0] word,
                              input logic signed [OFF_W-1:0] off,
                              input logic [CNT_W-1:0] cnt);
    if (src_idling && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= op;
    value_i <= word;
    offset_i <= off;
    count_i <= cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    results_due.push_back(apply_request(op, word, off, cnt));
  endtask

  task automatic send_random_request();
    mode_e op;
    int n, span, q;
    logic signed [OFF_W-1:0] off;
    logic [CNT_W-1:0] cnt;
    n = stack_level;
    op = mode_e'($urandom_range(0, 15));
    if (op == MODE_CLEAR && $urandom_range(0, 3) != 0) op = MODE_PUSH;
    if ($urandom_range(0, 4) == 0) op = (n > 48) ? MODE_DROP : MODE_PUSH;
    case ($urandom_range(0, 9))
      0: cnt = CNT_W'($urandom_range(0, 511));
      1: cnt = CNT_W'($urandom_range(0, STACK_WORDS));
      default: cnt = CNT_W'($urandom_range(0, (n < 10 ? n : 10) + 1));
    endcase
    span = (op == MODE_INSERT || op == MODE_DELETE) ? n + 1 : n;
    if (span == 0 || $urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 3) == 0) off = OFF_W'($urandom);
      else off = OFF_W'(int'($urandom_range(0, 513)) - 257);
    end else begin
      // aim at a live position, from the bottom or from the top
      q = $urandom_range(0, span - 1);
      if (op == MODE_DELETE) off = $urandom_range(0, 1) ? OFF_W'(-q - 1) : OFF_W'(n - q);
      else off = $urandom_range(0, 1) ? OFF_W'(q) : OFF_W'(q - n - 1);
    end
    send_request(op, random_word(), off, cnt);
  endtask

  task automatic test_directed();
    send_request(MODE_POP, '0, 10'sd0, 9'd0);
    send_request(MODE_READ, '0, -10'sd2, 9'd0);
    send_request(MODE_DELETE, '0, 10'sd0, 9'd1);
    send_request(MODE_PUSH, 64'h7FFF_FFFF_FFFF_FFFF, 10'sd0, 9'd0);
    send_request(MODE_PUSH, 64'h8000_0000_0000_0000, 10'sd0, 9'd0);
    send_request(MODE_PUSH, 64'h0, 10'sd0, 9'd0);
    send_request(MODE_PUSH, '1, 10'sd0, 9'd0);
    send_request(MODE_DUP, '0, 10'sd0, 9'd0);
    send_request(MODE_OVER, '0, 10'sd0, 9'd0);
    send_request(MODE_SWAP, '0, 10'sd0, 9'd0);
    send_request(MODE_NIP, '0, 10'sd0, 9'd0);
    send_request(MODE_TUCK, '0, 10'sd0, 9'd0);
    send_request(MODE_PICK, '0, 10'sd0, 9'd0);
    send_request(MODE_PICK, '0, -10'sd2, 9'd0);
    send_request(MODE_ROLL_UP, '0, 10'sd0, 9'd3);
    send_request(MODE_ROLL_DOWN, '0, 10'sd0, 9'd4);
    send_request(MODE_ROLL_UP, '0, 10'sd0, 9'd1);
    send_request(MODE_ROLL_DOWN, '0, 10'sd0, 9'd0);
    send_request(MODE_READ, '0, -10'sd2, 9'd0);
    send_request(MODE_WRITE, 64'h0123_4567_89AB_CDEF, 10'sd1, 9'd0);
    send_request(MODE_INSERT, 64'hFEDC_BA98_7654_3210, -10'sd1, 9'd0);
    send_request(MODE_INSERT, 64'h5555_AAAA_5555_AAAA, 10'sd0, 9'd0);
    send_request(MODE_DELETE, '0, 10'sd1, 9'd2);
    send_request(MODE_DELETE, '0, -10'sd1, 9'd0);
    send_request(MODE_READ, '0, -10'sd257, 9'd0);
    send_request(MODE_DROP, '0, 10'sd0, 9'd256);
    send_request(MODE_CLEAR, '0, 10'sd0, 9'd0);
    send_request(MODE_WRITE, '1, 10'sd256, 9'd0);
  endtask

  task automatic test_fill_and_overflow();
    while (stack_level < STACK_WORDS)
      send_request(MODE_PUSH, random_word(), OFF_W'($urandom), CNT_W'($urandom));
    send_request(MODE_PUSH, random_word(), 10'sd0, 9'd0);
    send_request(MODE_DUP, '0, 10'sd0, 9'd0);
    send_request(MODE_OVER, '0, 10'sd0, 9'd0);
    send_request(MODE_TUCK, '0, 10'sd0, 9'd0);
    send_request(MODE_PICK, '0, 10'sd0, 9'd0);
    send_request(MODE_PICK, '0, 10'sd256, 9'd0);
    send_request(MODE_INSERT, random_word(), -10'sd1, 9'd0);
    send_request(MODE_READ, '0, -10'sd257, 9'd0);
    send_request(MODE_READ, '0, 10'sd255, 9'd0);
    send_request(MODE_WRITE, random_word(), -10'sd2, 9'd0);
    send_request(MODE_ROLL_UP, '0, 10'sd0, 9'd256);
    send_request(MODE_ROLL_DOWN, '0, 10'sd0, 9'd256);
    send_request(MODE_ROLL_UP, '0, 10'sd0, 9'd257);
    send_request(MODE_DROP, '0, 10'sd0, 9'd511);
    send_request(MODE_DELETE, '0, 10'sd0, 9'd250);
  endtask

  task automatic test_random_ops();
    for (int k = 0; k < 140; k++) begin
      if (k % 30 == 0) begin
        src_idling = $urandom_range(0, 1);
        sink_idling = $urandom_range(0, 1);
      end
      send_random_request();
    end
    src_idling = 1'b1;
    sink_idling = 1'b1;
  endtask

  task automatic test_output_hold();
    src_idling = 1'b0;
    sink_idling = 1'b0;
    hold_cycles = 300;
    repeat (10) send_random_request();
    src_idling = 1'b1;
    sink_idling = 1'b1;
  endtask

  task automatic test_no_idle_tail();
    src_idling = 1'b0;
    sink_idling = 1'b0;
    repeat (40) send_random_request();
  endtask

  initial begin : result_sink
    int span;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        span = hold_cycles;
        hold_cycles = 0;
        out_stall_i <= 1'b1;
        repeat (span) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_idling && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    stack_result_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result word=%h depth=%0d error=%0d",
                 $time, result_word_o, depth_o, error_o);
        failures++;
      end else begin
        due = results_due.pop_front();
        if (result_word_o !== due.word) begin
          $display("%0t: result_word expected %h actual %h", $time, due.word, result_word_o);
          failures++;
        end
        if (depth_o !== due.depth) begin
          $display("%0t: depth expected %0d actual %0d", $time, due.depth, depth_o);
          failures++;
        end
        if (error_o !== due.error) begin
          $display("%0t: error expected %0d actual %0d", $time, due.error, error_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_and_overflow();
    test_random_ops();
    test_output_hold();
    test_no_idle_tail();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (failures == 0 && results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
